// ----- hw/rtl/scc_pkg.sv -----
`default_nettype none

package scc_pkg;

  // Item kinds on the input channel
  typedef enum logic [3:0] {
    KIND_TICK        = 4'd0,
    KIND_PULSE_NOTE  = 4'd1,
    KIND_PULSE_VOL   = 4'd2,
    KIND_TRI_NOTE    = 4'd3,
    KIND_TRI_LOW     = 4'd4,
    KIND_LINEAR_SET  = 4'd5,
    KIND_TRI_MUTE    = 4'd6,
    KIND_NOISE_SET   = 4'd7,
    KIND_FRAME_WRITE = 4'd8
  } scc_kind_t;

  // Frame sequencer step points (sequencer count values)
  localparam logic [14:0] SEQ_Q1  = 15'd3729;
  localparam logic [14:0] SEQ_QH1 = 15'd7457;
  localparam logic [14:0] SEQ_Q2  = 15'd11186;
  localparam logic [14:0] SEQ_QH2 = 15'd14915;
  localparam logic [14:0] SEQ_END = 15'd18641;

  // Video dots per frame, dots per CPU cycle
  localparam logic [16:0] DOTS_PER_FRAME = 17'd89342;
  localparam logic [16:0] DOTS_PER_TICK  = 17'd3;

  localparam logic [7:0] NOTE_LEN = 8'd254;

  // Frame counter write delays by parity
  localparam logic [2:0] DELAY_ODD  = 3'd3;
  localparam logic [2:0] DELAY_EVEN = 3'd4;

  // Per-channel control for a pulse unit
  typedef struct packed {
    logic note_load;  // note with nonzero period
    logic vol_write;  // volume only
    logic step;       // timer step (even cycle)
    logic half;       // half-frame length clock
  } scc_pulse_ctrl_t;

  // Noise timer reload table
  function automatic logic [11:0] noise_period(input logic [3:0] idx);
    logic [11:0] p;
    case (idx)
      4'd0:    p = 12'd4;
      4'd1:    p = 12'd8;
      4'd2:    p = 12'd16;
      4'd3:    p = 12'd32;
      4'd4:    p = 12'd64;
      4'd5:    p = 12'd96;
      4'd6:    p = 12'd128;
      4'd7:    p = 12'd160;
      4'd8:    p = 12'd202;
      4'd9:    p = 12'd254;
      4'd10:   p = 12'd380;
      4'd11:   p = 12'd508;
      4'd12:   p = 12'd762;
      4'd13:   p = 12'd1016;
      4'd14:   p = 12'd2034;
      default: p = 12'd4068;
    endcase
    return p;
  endfunction

  // Duty pattern bit at a given phase
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] phase);
    logic [7:0] pat;
    case (duty)
      2'd0:    pat = 8'h02;
      2'd1:    pat = 8'h06;
      2'd2:    pat = 8'h1E;
      default: pat = 8'hF9;
    endcase
    return pat[phase];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sound_channel_clock_core.sv -----
`default_nettype none

// Channel  | Handshake             | Payload
// in_      | in_valid / in_ready   | kind, channel, period, duty, volume, byte_value,
//          |                       | lin_reload, linear_hold, noise_period_index
// out_     | out_valid / out_ready | four channel levels, frame_tick
//
// One item per clock sustained while out_ready is held; the result appears in the cycle after transfer.
// All state updates happen at the input transfer edge; the result register
// holds the levels until taken, and a new item is accepted whenever that
// register is empty or being emptied in the same cycle.
// Synchronous active-low reset clears all state but the result payload, LFSR to 1.
module sound_channel_clock_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_kind,
  input  wire logic        in_channel,
  input  wire logic [10:0] in_period,
  input  wire logic [1:0]  in_duty,
  input  wire logic [3:0]  in_volume,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [6:0]  in_lin_reload,
  input  wire logic        in_linear_hold,
  input  wire logic [3:0]  in_noise_period_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_pulse_one_level,
  output logic [3:0]       out_pulse_two_level,
  output logic [3:0]       out_triangle_level,
  output logic [3:0]       out_noise_level,
  output logic             out_frame_tick
);
  import scc_pkg::*;

  logic accept;
  logic is_tick, is_frame_write;

  // Shared sequencer state
  logic        parity_r,   parity_nxt;
  logic [2:0]  delay_r,    delay_nxt;
  logic [14:0] seq_r,      seq_nxt;
  logic [16:0] dots_r,     dots_nxt;
  logic [14:0] seq_inc;
  logic [16:0] dots_sum;
  logic        quarter, half, frame_wrap;

  // Triangle state
  logic [10:0] tri_period_r, tri_period_nxt;
  logic [10:0] tri_timer_r,  tri_timer_nxt;
  logic [4:0]  tri_phase_r,  tri_phase_nxt;
  logic [7:0]  tri_length_r, tri_length_nxt;
  logic [6:0]  tri_linear_r, tri_linear_nxt;
  logic [6:0]  tri_reload_r, tri_reload_nxt;
  logic        tri_pending_r, tri_pending_nxt;
  logic        tri_hold_r,   tri_hold_nxt;

  // Noise state
  logic [11:0] noise_cnt_r,    noise_cnt_nxt;
  logic [14:0] noise_lfsr_r,   noise_lfsr_nxt;
  logic [3:0]  noise_rate_r,   noise_rate_nxt;
  logic [3:0]  noise_volume_r, noise_volume_nxt;
  logic [7:0]  noise_length_r, noise_length_nxt;

  // Pulse units
  scc_pulse_ctrl_t pulse_ctrl [2];
  logic [3:0]      pulse_level [2];

  // Result register
  logic       out_valid_r;
  logic [3:0] p1_r, p2_r, tri_lvl_r, noise_lvl_r;
  logic       ftick_r;
  logic [3:0] tri_lvl_nxt, noise_lvl_nxt;

  assign in_ready       = !out_valid_r || out_ready;
  assign accept         = in_valid && in_ready;
  assign is_tick        = accept && (in_kind == KIND_TICK);
  assign is_frame_write = accept && (in_kind == KIND_FRAME_WRITE);

  // Frame sequencer, parity and dot counter
  assign seq_inc  = seq_r + 15'd1;
  assign dots_sum = dots_r + DOTS_PER_TICK;

  always_comb begin
    parity_nxt = parity_r;
    delay_nxt  = delay_r;
    seq_nxt    = seq_r;
    dots_nxt   = dots_r;
    quarter    = 1'b0;
    half       = 1'b0;
    frame_wrap = 1'b0;
    if (is_tick) begin
      parity_nxt = !parity_r;
      if (delay_r != 3'd0) begin
        delay_nxt = delay_r - 3'd1;
        if (delay_r == 3'd1) begin
          seq_nxt = '0;
          quarter = 1'b1;
          half    = 1'b1;
        end
      end else begin
        seq_nxt = seq_inc;
        if (seq_inc == SEQ_Q1 || seq_inc == SEQ_Q2) begin
          quarter = 1'b1;
        end else if (seq_inc == SEQ_QH1 || seq_inc == SEQ_QH2) begin
          quarter = 1'b1;
          half    = 1'b1;
        end else if (seq_inc >= SEQ_END) begin
          seq_nxt = '0;
        end
      end
      if (dots_sum >= DOTS_PER_FRAME) begin
        dots_nxt   = dots_sum - DOTS_PER_FRAME;
        frame_wrap = 1'b1;
      end else begin
        dots_nxt = dots_sum;
      end
    end
    if (is_frame_write) begin
      delay_nxt = parity_r ? DELAY_ODD : DELAY_EVEN;
    end
  end

  // Triangle channel
  always_comb begin
    tri_period_nxt  = tri_period_r;
    tri_timer_nxt   = tri_timer_r;
    tri_phase_nxt   = tri_phase_r;
    tri_length_nxt  = tri_length_r;
    tri_linear_nxt  = tri_linear_r;
    tri_reload_nxt  = tri_reload_r;
    tri_pending_nxt = tri_pending_r;
    tri_hold_nxt    = tri_hold_r;
    if (is_tick) begin
      if (tri_timer_r == 11'd0) begin
        tri_timer_nxt = tri_period_r;
        tri_phase_nxt = tri_phase_r + 5'd1;
      end else begin
        tri_timer_nxt = tri_timer_r - 11'd1;
      end
    end
    if (quarter) begin
      if (tri_pending_r) begin
        tri_linear_nxt = tri_reload_r;
      end else if (tri_linear_r != 7'd0) begin
        tri_linear_nxt = tri_linear_r - 7'd1;
      end
      if (!tri_hold_r) begin
        tri_pending_nxt = 1'b0;
      end
    end
    if (half && !tri_hold_r && tri_length_r != 8'd0) begin
      tri_length_nxt = tri_length_r - 8'd1;
    end
    if (accept) begin
      case (in_kind)
        KIND_TRI_NOTE: begin
          if (in_period != 11'd0) begin
            tri_period_nxt  = in_period;
            tri_timer_nxt   = in_period;
            tri_phase_nxt   = 5'd0;
            tri_length_nxt  = NOTE_LEN;
            tri_pending_nxt = 1'b1;
          end
        end
        KIND_TRI_LOW: begin
          tri_period_nxt = {tri_period_r[10:8], in_byte_value};
        end
        KIND_LINEAR_SET: begin
          tri_reload_nxt = in_lin_reload;
          tri_hold_nxt   = in_linear_hold;
        end
        KIND_TRI_MUTE: begin
          tri_linear_nxt = 7'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Noise channel
  always_comb begin
    noise_cnt_nxt    = noise_cnt_r;
    noise_lfsr_nxt   = noise_lfsr_r;
    noise_rate_nxt   = noise_rate_r;
    noise_volume_nxt = noise_volume_r;
    noise_length_nxt = noise_length_r;
    if (is_tick) begin
      if (noise_cnt_r == 12'd0) begin
        noise_cnt_nxt  = noise_period(noise_rate_r);
        noise_lfsr_nxt = {noise_lfsr_r[0] ^ noise_lfsr_r[1], noise_lfsr_r[14:1]};
      end else begin
        noise_cnt_nxt = noise_cnt_r - 12'd1;
      end
    end
    if (half && noise_length_r != 8'd0) begin
      noise_length_nxt = noise_length_r - 8'd1;
    end
    if (accept && in_kind == KIND_NOISE_SET) begin
      noise_volume_nxt = in_volume;
      noise_rate_nxt   = in_noise_period_index;
      noise_length_nxt = in_byte_value;
    end
  end

  // Pulse controls; timers step on ticks that leave parity even
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pulse_ctrl[k].note_load = accept && in_kind == KIND_PULSE_NOTE &&
                                in_channel == k[0] && in_period != 11'd0;
      pulse_ctrl[k].vol_write = accept && in_kind == KIND_PULSE_VOL &&
                                in_channel == k[0];
      pulse_ctrl[k].step      = is_tick && parity_r;
      pulse_ctrl[k].half      = half;
    end
  end

  scc_pulse u_pulse_one (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (pulse_ctrl[0]),
    .period    (in_period),
    .duty      (in_duty),
    .volume    (in_volume),
    .level_nxt (pulse_level[0])
  );

  scc_pulse u_pulse_two (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (pulse_ctrl[1]),
    .period    (in_period),
    .duty      (in_duty),
    .volume    (in_volume),
    .level_nxt (pulse_level[1])
  );

  // Levels after this item
  always_comb begin
    tri_lvl_nxt = 4'd0;
    if (tri_length_nxt != 8'd0 && tri_linear_nxt != 7'd0) begin
      tri_lvl_nxt = tri_phase_nxt[4] ? tri_phase_nxt[3:0] : ~tri_phase_nxt[3:0];
    end
    noise_lvl_nxt = (noise_length_nxt != 8'd0 && !noise_lfsr_nxt[0]) ?
                    noise_volume_nxt : 4'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r       <= 1'b0;
      delay_r        <= '0;
      seq_r          <= '0;
      dots_r         <= '0;
      tri_period_r   <= '0;
      tri_timer_r    <= '0;
      tri_phase_r    <= '0;
      tri_length_r   <= '0;
      tri_linear_r   <= '0;
      tri_reload_r   <= '0;
      tri_pending_r  <= 1'b0;
      tri_hold_r     <= 1'b0;
      noise_cnt_r    <= '0;
      noise_lfsr_r   <= 15'd1;
      noise_rate_r   <= '0;
      noise_volume_r <= '0;
      noise_length_r <= '0;
    end else begin
      parity_r       <= parity_nxt;
      delay_r        <= delay_nxt;
      seq_r          <= seq_nxt;
      dots_r         <= dots_nxt;
      tri_period_r   <= tri_period_nxt;
      tri_timer_r    <= tri_timer_nxt;
      tri_phase_r    <= tri_phase_nxt;
      tri_length_r   <= tri_length_nxt;
      tri_linear_r   <= tri_linear_nxt;
      tri_reload_r   <= tri_reload_nxt;
      tri_pending_r  <= tri_pending_nxt;
      tri_hold_r     <= tri_hold_nxt;
      noise_cnt_r    <= noise_cnt_nxt;
      noise_lfsr_r   <= noise_lfsr_nxt;
      noise_rate_r   <= noise_rate_nxt;
      noise_volume_r <= noise_volume_nxt;
      noise_length_r <= noise_length_nxt;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r        <= pulse_level[0];
      p2_r        <= pulse_level[1];
      tri_lvl_r   <= tri_lvl_nxt;
      noise_lvl_r <= noise_lvl_nxt;
      ftick_r     <= frame_wrap;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_one_level = p1_r;
  assign out_pulse_two_level = p2_r;
  assign out_triangle_level  = tri_lvl_r;
  assign out_noise_level     = noise_lvl_r;
  assign out_frame_tick      = ftick_r;

endmodule

`default_nettype wire

// ----- hw/rtl/scc_pulse.sv -----
`default_nettype none

module scc_pulse (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire scc_pkg::scc_pulse_ctrl_t ctrl,
  input  wire logic [10:0]              period,
  input  wire logic [1:0]               duty,
  input  wire logic [3:0]               volume,
  output logic [3:0]                    level_nxt
);
  import scc_pkg::*;

  logic [10:0] period_r, period_nxt;
  logic [10:0] timer_r,  timer_nxt;
  logic [2:0]  phase_r,  phase_nxt;
  logic [1:0]  duty_r,   duty_nxt;
  logic [3:0]  volume_r, volume_nxt;
  logic [7:0]  length_r, length_nxt;

  // Next state: note load, volume write, or timer/length clocks
  always_comb begin
    period_nxt = period_r;
    timer_nxt  = timer_r;
    phase_nxt  = phase_r;
    duty_nxt   = duty_r;
    volume_nxt = volume_r;
    length_nxt = length_r;
    if (ctrl.note_load) begin
      period_nxt = period;
      timer_nxt  = period;
      phase_nxt  = 3'd0;
      duty_nxt   = duty;
      volume_nxt = volume;
      length_nxt = NOTE_LEN;
    end
    if (ctrl.vol_write) begin
      volume_nxt = volume;
    end
    if (ctrl.step) begin
      if (timer_r == 11'd0) begin
        timer_nxt = period_r;
        phase_nxt = phase_r + 3'd1;
      end else begin
        timer_nxt = timer_r - 11'd1;
      end
    end
    if (ctrl.half && length_r != 8'd0) begin
      length_nxt = length_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      timer_r  <= '0;
      phase_r  <= '0;
      duty_r   <= '0;
      volume_r <= '0;
      length_r <= '0;
    end else begin
      period_r <= period_nxt;
      timer_r  <= timer_nxt;
      phase_r  <= phase_nxt;
      duty_r   <= duty_nxt;
      volume_r <= volume_nxt;
      length_r <= length_nxt;
    end
  end

  // Level after this item; period below 8 is silent
  assign level_nxt = (length_nxt != 8'd0 && period_nxt[10:3] != 8'd0 &&
                      duty_bit(duty_nxt, phase_nxt)) ? volume_nxt : 4'd0;

endmodule

`default_nettype wire
